// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property violated");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/pte_pkg.sv =====
// Types, register indexes and the micro-program of the Penning trap Euler stepper.
// Standalone package; used by penning_trap_euler_step_top.
package pte_pkg;

	localparam int WORD_W  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int PC_W    = 6;
	localparam int PROG_LEN = 39;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP      = 3'd0,
		REG_FIELD_GRADIENT = 3'd1,
		REG_MAGNETIC_FIELD = 3'd2,
		REG_QM_A           = 3'd3,
		REG_QM_B           = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,  // product register <= a * b
		OP_RND = 2'd1,  // dst <= sat(round(product))
		OP_ADD = 2'd2,  // dst <= sat(a + b)
		OP_SUB = 2'd3   // dst <= sat(a - b)
	} opcode_t;

	typedef enum logic [3:0] {
		SRC_ZERO = 4'd0,
		SRC_DT   = 4'd1,
		SRC_K    = 4'd2,
		SRC_B    = 4'd3,
		SRC_QM   = 4'd4,
		SRC_X    = 4'd5,
		SRC_Y    = 4'd6,
		SRC_Z    = 4'd7,
		SRC_VX   = 4'd8,
		SRC_VY   = 4'd9,
		SRC_VZ   = 4'd10,
		SRC_T0   = 4'd11,
		SRC_T1   = 4'd12
	} src_t;

	typedef enum logic [2:0] {
		DST_T0  = 3'd0,
		DST_T1  = 3'd1,
		DST_NX  = 3'd2,
		DST_NY  = 3'd3,
		DST_NZ  = 3'd4,
		DST_NVX = 3'd5,
		DST_NVY = 3'd6,
		DST_NVZ = 3'd7
	} dst_t;

	typedef struct packed {
		opcode_t op;
		src_t    a;
		src_t    b;
		dst_t    dst;
	} uop_t;

	// One particle's update; dependencies are honored by order alone.
	function automatic uop_t prog_op(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T0};
		case (pc)
			// positions
			6'd0:  u = '{OP_MUL, SRC_DT, SRC_VX, DST_T0};
			6'd1:  u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd2:  u = '{OP_ADD, SRC_X, SRC_T0, DST_NX};
			6'd3:  u = '{OP_MUL, SRC_DT, SRC_VY, DST_T0};
			6'd4:  u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd5:  u = '{OP_ADD, SRC_Y, SRC_T0, DST_NY};
			6'd6:  u = '{OP_MUL, SRC_DT, SRC_VZ, DST_T0};
			6'd7:  u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd8:  u = '{OP_ADD, SRC_Z, SRC_T0, DST_NZ};
			// x velocity: fx = k*x + vy*B
			6'd9:  u = '{OP_MUL, SRC_K, SRC_X, DST_T0};
			6'd10: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd11: u = '{OP_MUL, SRC_VY, SRC_B, DST_T1};
			6'd12: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T1};
			6'd13: u = '{OP_ADD, SRC_T0, SRC_T1, DST_T0};
			6'd14: u = '{OP_MUL, SRC_QM, SRC_T0, DST_T0};
			6'd15: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd16: u = '{OP_MUL, SRC_DT, SRC_T0, DST_T0};
			6'd17: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd18: u = '{OP_ADD, SRC_VX, SRC_T0, DST_NVX};
			// y velocity: fy = k*y - vx*B
			6'd19: u = '{OP_MUL, SRC_K, SRC_Y, DST_T0};
			6'd20: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd21: u = '{OP_MUL, SRC_VX, SRC_B, DST_T1};
			6'd22: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T1};
			6'd23: u = '{OP_SUB, SRC_T0, SRC_T1, DST_T0};
			6'd24: u = '{OP_MUL, SRC_QM, SRC_T0, DST_T0};
			6'd25: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd26: u = '{OP_MUL, SRC_DT, SRC_T0, DST_T0};
			6'd27: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd28: u = '{OP_ADD, SRC_VY, SRC_T0, DST_NVY};
			// z velocity: fz = -(2*(k*z))
			6'd29: u = '{OP_MUL, SRC_K, SRC_Z, DST_T0};
			6'd30: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd31: u = '{OP_ADD, SRC_T0, SRC_T0, DST_T0};
			6'd32: u = '{OP_SUB, SRC_ZERO, SRC_T0, DST_T0};
			6'd33: u = '{OP_MUL, SRC_QM, SRC_T0, DST_T0};
			6'd34: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd35: u = '{OP_MUL, SRC_DT, SRC_T0, DST_T0};
			6'd36: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T0};
			6'd37: u = '{OP_ADD, SRC_VZ, SRC_T0, DST_NVZ};
			6'd38: u = '{OP_ADD, SRC_VZ, SRC_T0, DST_NVZ};
			default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T0};
		endcase
		return u;
	endfunction

endpackage

// ===== hw/rtl/penning_trap_euler_step_top.sv =====
// Forward Euler stepper for charged particles in an ideal Penning trap.
// Depends on pte_pkg and assert_macros.svh.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes dt, k, B0 and the
//    two charge/mass ratios; cfg_ready is always high, write only while idle.
//  - s_axis carries one request per transfer: tuser[0] = kind (load/step),
//    tuser[1] = particle index, tdata = pos x,y,z then vel x,y,z (32 bits each).
//  - A load request writes one particle's state in the accept cycle and yields
//    nothing; the next request can follow in the next cycle.
//  - A step request runs the micro-program per particle on one shared
//    32x32 multiplier / saturating adder, then posts the result from an emit
//    state, which waits while the output register holds an untaken result.
//  - m_axis returns one result per particle in index order: tuser[0] = particle,
//    tuser[1] = saturated, tlast on the final particle.
//  - The output register holds a result until taken; while a finished result
//    waits the sequencer stalls before posting the next one, and s_axis_tready
//    is high whenever the sequencer is idle, even with a result still waiting.
//  - Reset (arst_n low) clears sequencer, config and particle state to zero and
//    drops m_axis_tvalid; datapath and output data registers are not reset.
`include "assert_macros.svh"

module penning_trap_euler_step_top #(
	parameter int PARTICLES = 2,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// requests in
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in
	input  logic [1:0]   s_axis_tuser,  // kind, particle_index
	// results out
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out
	output logic [1:0]   m_axis_tuser,  // particle_out, saturated
	output logic         m_axis_tlast
);

	localparam int W = pte_pkg::WORD_W;
	localparam int PIDX_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	localparam logic [pte_pkg::PC_W-1:0] PC_LAST = pte_pkg::PC_W'(pte_pkg::PROG_LEN - 1);
	localparam logic [PIDX_W-1:0] P_LAST = PIDX_W'(PARTICLES - 1);
	localparam logic signed [2*W-1:0] RND_HALF = (2*W)'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	logic [pte_pkg::PC_W-1:0] pc_q;
	logic [PIDX_W-1:0] cur_q;
	logic sat_q;

	// configuration registers
	logic [30:0] dt_q;
	logic signed [W-1:0] k_q, b_q, qm_a_q, qm_b_q;

	// particle state
	logic signed [W-1:0] pos_q [PARTICLES][3];
	logic signed [W-1:0] vel_q [PARTICLES][3];

	// working registers of the shared unit
	logic signed [2*W-1:0] prod_q;
	logic signed [W-1:0] t0_q, t1_q;
	logic signed [W-1:0] npos_q [3];
	logic signed [W-1:0] nvel_q [3];

	// output stage
	logic out_valid_q;
	logic [191:0] out_data_q;
	logic [1:0] out_user_q;
	logic out_last_q;

	pte_pkg::uop_t uop;
	logic signed [W-1:0] opa, opb, qm;
	logic signed [2*W-1:0] rnd_sum, rnd_shr;
	logic rnd_ovf;
	logic signed [W-1:0] rnd_val;
	logic signed [W:0] sum33;
	logic sum_ovf;
	logic signed [W-1:0] sum_val;
	logic signed [W-1:0] res_val;
	logic res_sat;
	logic in_fire, load_ok, emit_go, cur_is_last;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign load_ok = (32'(s_axis_tuser[1]) < 32'(PARTICLES));
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign cur_is_last = (cur_q == P_LAST);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	assign uop = pte_pkg::prog_op(pc_q);
	assign qm = (cur_q == '0) ? qm_a_q : qm_b_q;

	function automatic logic signed [W-1:0] pick(
		input pte_pkg::src_t s,
		input logic [30:0] dt,
		input logic signed [W-1:0] k, b, q, x, y, z, vx, vy, vz, t0, t1
	);
		logic signed [W-1:0] v;
		v = '0;
		unique case (s)
			pte_pkg::SRC_ZERO: v = '0;
			pte_pkg::SRC_DT:   v = {1'b0, dt};
			pte_pkg::SRC_K:    v = k;
			pte_pkg::SRC_B:    v = b;
			pte_pkg::SRC_QM:   v = q;
			pte_pkg::SRC_X:    v = x;
			pte_pkg::SRC_Y:    v = y;
			pte_pkg::SRC_Z:    v = z;
			pte_pkg::SRC_VX:   v = vx;
			pte_pkg::SRC_VY:   v = vy;
			pte_pkg::SRC_VZ:   v = vz;
			pte_pkg::SRC_T0:   v = t0;
			pte_pkg::SRC_T1:   v = t1;
			default:           v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(uop.a, dt_q, k_q, b_q, qm,
			pos_q[cur_q][0], pos_q[cur_q][1], pos_q[cur_q][2],
			vel_q[cur_q][0], vel_q[cur_q][1], vel_q[cur_q][2], t0_q, t1_q);
		opb = pick(uop.b, dt_q, k_q, b_q, qm,
			pos_q[cur_q][0], pos_q[cur_q][1], pos_q[cur_q][2],
			vel_q[cur_q][0], vel_q[cur_q][1], vel_q[cur_q][2], t0_q, t1_q);
	end

	// round half up at FRAC_BITS, floor via arithmetic shift, clip to 32 bits
	always_comb begin
		rnd_sum = prod_q + RND_HALF;
		rnd_shr = rnd_sum >>> FRAC_BITS;
		rnd_ovf = !((&rnd_shr[2*W-1:W-1]) || !(|rnd_shr[2*W-1:W-1]));
		rnd_val = rnd_ovf ? (rnd_shr[2*W-1] ? SMIN : SMAX) : rnd_shr[W-1:0];
	end

	always_comb begin
		if (uop.op == pte_pkg::OP_SUB) begin
			sum33 = {opa[W-1], opa} - {opb[W-1], opb};
		end else begin
			sum33 = {opa[W-1], opa} + {opb[W-1], opb};
		end
		sum_ovf = (sum33[W] != sum33[W-1]);
		sum_val = sum_ovf ? (sum33[W] ? SMIN : SMAX) : sum33[W-1:0];
	end

	always_comb begin
		res_val = sum_val;
		res_sat = 1'b0;
		case (uop.op)
			pte_pkg::OP_MUL: begin
				res_val = sum_val;
				res_sat = 1'b0;
			end
			pte_pkg::OP_RND: begin
				res_val = rnd_val;
				res_sat = rnd_ovf;
			end
			default: begin
				res_val = sum_val;
				res_sat = sum_ovf;
			end
		endcase
	end

	// sequencer, particle state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			cur_q   <= '0;
			sat_q   <= 1'b0;
			dt_q    <= '0;
			k_q     <= '0;
			b_q     <= '0;
			qm_a_q  <= '0;
			qm_b_q  <= '0;
			for (int p = 0; p < PARTICLES; p++) begin
				for (int c = 0; c < 3; c++) begin
					pos_q[p][c] <= '0;
					vel_q[p][c] <= '0;
				end
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pte_pkg::REG_TIME_STEP:      dt_q   <= cfg_data[30:0];
					pte_pkg::REG_FIELD_GRADIENT: k_q    <= cfg_data;
					pte_pkg::REG_MAGNETIC_FIELD: b_q    <= cfg_data;
					pte_pkg::REG_QM_A:           qm_a_q <= cfg_data;
					pte_pkg::REG_QM_B:           qm_b_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser[0] == pte_pkg::KIND_STEP) begin
							state_q <= ST_RUN;
							pc_q    <= '0;
							cur_q   <= '0;
							sat_q   <= 1'b0;
						end else if (load_ok) begin
							for (int c = 0; c < 3; c++) begin
								pos_q[PIDX_W'(s_axis_tuser[1])][c] <= s_axis_tdata[c*W +: W];
								vel_q[PIDX_W'(s_axis_tuser[1])][c] <=
									s_axis_tdata[(c+3)*W +: W];
							end
						end
					end
				end
				ST_RUN: begin
					if (uop.op != pte_pkg::OP_MUL) begin
						sat_q <= sat_q | res_sat;
					end
					if (pc_q == PC_LAST) begin
						state_q <= ST_EMIT;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						for (int c = 0; c < 3; c++) begin
							pos_q[cur_q][c] <= npos_q[c];
							vel_q[cur_q][c] <= nvel_q[c];
						end
						if (cur_is_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							cur_q   <= cur_q + 1'b1;
							pc_q    <= '0;
							sat_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared unit datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (uop.op)
				pte_pkg::OP_MUL: prod_q <= opa * opb;
				default: begin
					unique case (uop.dst)
						pte_pkg::DST_T0:  t0_q      <= res_val;
						pte_pkg::DST_T1:  t1_q      <= res_val;
						pte_pkg::DST_NX:  npos_q[0] <= res_val;
						pte_pkg::DST_NY:  npos_q[1] <= res_val;
						pte_pkg::DST_NZ:  npos_q[2] <= res_val;
						pte_pkg::DST_NVX: nvel_q[0] <= res_val;
						pte_pkg::DST_NVY: nvel_q[1] <= res_val;
						pte_pkg::DST_NVZ: nvel_q[2] <= res_val;
						default: ;
					endcase
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_data_q <= {nvel_q[2], nvel_q[1], nvel_q[0], npos_q[2], npos_q[1], npos_q[0]};
			out_user_q <= {sat_q, 1'(cur_q)};
			out_last_q <= cur_is_last;
		end
	end

	// a step request always starts particle zero at the top of the program
	`ASSERT_AT(a_step_start, clk, arst_n,
		(in_fire && s_axis_tuser[0] == pte_pkg::KIND_STEP) |=>
		(state_q == ST_RUN && pc_q == '0 && cur_q == '0))

	// the program is run to its end before a result is posted
	`ASSERT_AT(a_emit_after_prog, clk, arst_n,
		(state_q == ST_EMIT && $past(state_q) == ST_RUN) |-> ($past(pc_q) == PC_LAST))

	// a waiting result is never overwritten by the next particle
	`ASSERT_AT(a_emit_holds, clk, arst_n,
		(state_q == ST_EMIT && out_valid_q && !m_axis_tready) |=> (state_q == ST_EMIT))

endmodule
